[sv/midi_output_queue_note_off_keep_core_macros.svh]
// Assertion macros shared by the queue RTL.
// Both macros expect clk and rst_n in scope.
`ifndef MIDI_OUTPUT_QUEUE_NOTE_OFF_KEEP_CORE_MACROS_SVH
`define MIDI_OUTPUT_QUEUE_NOTE_OFF_KEEP_CORE_MACROS_SVH

// Check a property at every rising clock edge outside reset.
`define MOQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition in one cycle implies another in the next cycle.
`define MOQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[sv/moq_pkg.sv]
`timescale 1ns / 1ps
package moq_pkg;

  localparam int SLOT_COUNT  = 16;
  localparam int NUM_MODULES = 4;
  localparam int OCC_W       = $clog2(SLOT_COUNT + 1);
  localparam int IDX_W       = $clog2(SLOT_COUNT);
  localparam int MOD_W       = 2;

  // Batch limit arithmetic: (max(frame, 24) - 17) / 5
  localparam logic [7:0]  FRAME_MIN  = 8'd24;
  localparam logic [7:0]  FRAME_HDR  = 8'd17;
  localparam logic [15:0] DIV5_MUL   = 16'd205;
  localparam int          DIV5_SHIFT = 10;

  localparam logic [3:0] NIB_NOTE_OFF = 4'h8;
  localparam logic [3:0] NIB_NOTE_ON  = 4'h9;

  // Configuration register indexes
  localparam logic [2:0] REG_QUEUE_LIMIT  = 3'd0;
  localparam logic [2:0] REG_MODULE_COUNT = 3'd1;
  localparam logic [2:0] REG_FIRST_PORTS  = 3'd2;
  localparam logic [2:0] REG_LAST_PORTS   = 3'd3;
  localparam logic [2:0] REG_PORT_COUNTS  = 3'd4;
  localparam logic [2:0] REG_FRAME_BYTES  = 3'd5;

  typedef enum logic [3:0] {
    ST_QUEUED     = 4'd0,
    ST_PORT_ZERO  = 4'd1,
    ST_BAD_LENGTH = 4'd2,
    ST_NOT_STATUS = 4'd3,
    ST_LOCAL_OOR  = 4'd4,
    ST_NO_ROUTE   = 4'd5,
    ST_OVERFLOW   = 4'd6,
    ST_ITEM       = 4'd7,
    ST_EMPTY      = 4'd8
  } status_t;

  // route: module[14:13] local[12:8] global[7:0]
  // msg:   count[25:24] b0[23:16] b1[15:8] b2[7:0]
  typedef struct packed {
    logic [14:0] route;
    logic [25:0] msg;
    logic [31:0] stamp;
  } entry_t;

  typedef struct packed {
    logic             scan;
    logic             pop;
    logic             load;
    logic [IDX_W-1:0] load_idx;
    logic [OCC_W-1:0] occ;
  } cell_ctrl_t;

  function automatic logic note_off(logic [1:0] cnt, logic [7:0] b0, logic [7:0] b2);
    logic res;
    res = 1'b0;
    if (cnt != 2'd0) begin
      if (b0[7:4] == NIB_NOTE_OFF) res = 1'b1;
      else if (b0[7:4] == NIB_NOTE_ON && cnt == 2'd3 && b2 == 8'd0) res = 1'b1;
    end
    return res;
  endfunction

  function automatic logic [5:0] drain_cap(logic [7:0] frame_bytes);
    logic [7:0]  frame;
    logic [15:0] prod;
    frame = (frame_bytes < FRAME_MIN) ? FRAME_MIN : frame_bytes;
    prod  = {8'd0, frame - FRAME_HDR} * DIV5_MUL;
    return prod[DIV5_SHIFT +: 6];
  endfunction

endpackage

[sv/midi_output_queue_note_off_keep_core.sv]
`timescale 1ns / 1ps
// Outbound MIDI queue for one bus. Each input word is latched and then
// executed. A drain emits one entry per cycle while the result side is not
// stalled (at most the 16 entries the queue holds), each popping the head of
// the cell chain. The queue is a row of cells that shift toward the head; on
// overflow the chain scans in the same cycle for the oldest entry that is not
// a Note Off and closes the gap, or pops the head when only Note Offs are held
// and the new word is a Note Off. The input side is stalled while a word is
// executing or its batch drains; the result register lets the next word be
// taken while a result still waits. Configuration writes are always ready.
module midi_output_queue_note_off_keep_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_action,
  input  logic [7:0]  in_global_port,
  input  logic [2:0]  in_byte_count,
  input  logic [7:0]  in_byte0,
  input  logic [7:0]  in_byte1,
  input  logic [7:0]  in_byte2,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  out_status,
  output logic        out_evicted,
  output logic [1:0]  out_module_id,
  output logic [4:0]  out_module_port,
  output logic [7:0]  out_out_global_port,
  output logic [1:0]  out_out_byte_count,
  output logic [7:0]  out_out_byte0,
  output logic [7:0]  out_out_byte1,
  output logic [7:0]  out_out_byte2,
  output logic [31:0] out_sequence_res,
  output logic        out_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);
  import moq_pkg::*;
  `include "midi_output_queue_note_off_keep_core_macros.svh"

  typedef enum logic [1:0] {S_IDLE, S_EXEC, S_DRAIN} state_t;

  state_t           state_r, state_nxt;
  logic [OCC_W-1:0] occ_r, occ_nxt;
  logic [31:0]      seq_r, seq_nxt;
  logic [MOD_W-1:0] mod_r, mod_nxt;
  logic [5:0]       limit_r, limit_nxt;
  logic [5:0]       cnt_r, cnt_nxt;

  // configuration
  logic [4:0]  queue_limit_r;
  logic [2:0]  module_count_r;
  logic [31:0] first_ports_r;
  logic [31:0] last_ports_r;
  logic [19:0] port_counts_r;
  logic [7:0]  frame_bytes_r;

  // latched input word
  logic       act_r;
  logic [7:0] gp_r;
  logic [2:0] bc_r;
  logic [7:0] b0_r, b1_r, b2_r;

  // result register
  logic   out_valid_r, out_valid_nxt;
  logic   emit;
  status_t res_status;
  logic   res_evicted;
  entry_t res_entry;
  logic   res_last;
  status_t out_status_r;
  logic   out_evicted_r;
  entry_t out_entry_r;
  logic   out_last_r;

  // cell chain
  cell_ctrl_t ctrl;
  entry_t     new_entry;
  entry_t     cell_q  [SLOT_COUNT];
  entry_t     right_d [SLOT_COUNT];
  logic       hit     [SLOT_COUNT+1];

  logic out_free;
  logic in_acc;

  assign out_free  = ~out_valid_r | ~out_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid & ~in_stall;
  assign cfg_ready = 1'b1;

  // Cell row
  assign hit[0] = 1'b0;
  for (genvar k = 0; k < SLOT_COUNT; k++) begin : g_cell
    if (k < SLOT_COUNT - 1) begin : g_mid
      assign right_d[k] = cell_q[k+1];
    end else begin : g_end
      assign right_d[k] = '0;
    end
    moq_cell u_cell (
      .clk        (clk),
      .cell_idx   (IDX_W'(k)),
      .ctrl       (ctrl),
      .hit_in     (hit[k]),
      .hit_out    (hit[k+1]),
      .right_data (right_d[k]),
      .new_data   (new_entry),
      .data       (cell_q[k])
    );
  end

  // Message checks and module search
  logic [2:0]       nm;
  logic [1:0]       cnt2;
  logic [7:0]       b1m, b2m;
  logic             found;
  logic [MOD_W-1:0] m_sel;
  logic [7:0]       first_sel;
  logic [4:0]       pc_sel;
  logic [8:0]       local9;
  logic [OCC_W-1:0] limit_eff;
  logic             at_limit;
  logic             any_keep;
  logic             inc_off;

  always_comb begin
    logic [7:0] f;
    logic [7:0] l;
    nm        = (module_count_r > 3'(NUM_MODULES)) ? 3'(NUM_MODULES) : module_count_r;
    cnt2      = bc_r[1:0];
    b1m       = (bc_r >= 3'd2) ? b1_r : 8'd0;
    b2m       = (bc_r >= 3'd3) ? b2_r : 8'd0;
    found     = 1'b0;
    m_sel     = '0;
    first_sel = '0;
    pc_sel    = '0;
    for (int m = 0; m < NUM_MODULES; m++) begin
      f = first_ports_r[8*m +: 8];
      l = last_ports_r[8*m +: 8];
      if (!found && 3'(m) < nm && gp_r >= f && gp_r <= l) begin
        found     = 1'b1;
        m_sel     = MOD_W'(m);
        first_sel = f;
        pc_sel    = port_counts_r[5*m +: 5];
      end
    end
    local9    = {1'b0, gp_r} - {1'b0, first_sel} + 9'd1;
    limit_eff = (queue_limit_r == 5'd0 || queue_limit_r > 5'(SLOT_COUNT)) ?
                OCC_W'(SLOT_COUNT) : OCC_W'(queue_limit_r);
    at_limit  = occ_r >= limit_eff;
    any_keep  = hit[SLOT_COUNT];
    inc_off   = note_off(cnt2, b0_r, b2m);
  end

  assign new_entry.route = {m_sel, local9[4:0], gp_r};
  assign new_entry.msg   = {cnt2, b0_r, b1m, b2m};
  assign new_entry.stamp = seq_r + 32'd1;

  // Sequencer: execute the latched word, then pop a batch on drain
  always_comb begin
    logic drain_more;
    state_nxt   = state_r;
    occ_nxt     = occ_r;
    seq_nxt     = seq_r;
    mod_nxt     = mod_r;
    limit_nxt   = limit_r;
    cnt_nxt     = cnt_r;
    ctrl        = '0;
    ctrl.occ    = occ_r;
    emit        = 1'b0;
    res_status  = ST_QUEUED;
    res_evicted = 1'b0;
    res_entry   = '0;
    res_last    = 1'b1;
    drain_more  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (out_free) begin
          if (act_r) begin
            if (occ_r == '0) begin
              emit       = 1'b1;
              res_status = ST_EMPTY;
              state_nxt  = S_IDLE;
            end else begin
              mod_nxt   = cell_q[0].route[14:13];
              limit_nxt = ({1'b0, cell_q[0].route[14:13]} < nm) ?
                          drain_cap(frame_bytes_r) : 6'd1;
              cnt_nxt   = '0;
              state_nxt = S_DRAIN;
            end
          end else begin
            emit      = 1'b1;
            state_nxt = S_IDLE;
            if (gp_r == 8'd0) res_status = ST_PORT_ZERO;
            else if (bc_r == 3'd0 || bc_r > 3'd3) res_status = ST_BAD_LENGTH;
            else if (!b0_r[7]) res_status = ST_NOT_STATUS;
            else if (!found) res_status = ST_NO_ROUTE;
            else if (local9 > {4'd0, pc_sel}) res_status = ST_LOCAL_OOR;
            else if (at_limit && !any_keep && !inc_off) res_status = ST_OVERFLOW;
            else begin
              // queue the word, evicting first when at the limit
              res_status    = ST_QUEUED;
              res_evicted   = at_limit;
              res_entry     = new_entry;
              seq_nxt       = seq_r + 32'd1;
              ctrl.load     = 1'b1;
              ctrl.scan     = at_limit & any_keep;
              ctrl.pop      = at_limit & ~any_keep;
              ctrl.load_idx = at_limit ? IDX_W'(occ_r - OCC_W'(1)) : occ_r[IDX_W-1:0];
              occ_nxt       = at_limit ? occ_r : occ_r + OCC_W'(1);
            end
          end
        end
      end
      S_DRAIN: begin
        if (out_free) begin
          drain_more = (occ_r > OCC_W'(1)) && (cnt_r + 6'd1 < limit_r) &&
                       (cell_q[1].route[14:13] == mod_r);
          emit       = 1'b1;
          res_status = ST_ITEM;
          res_entry  = cell_q[0];
          res_last   = ~drain_more;
          ctrl.pop   = 1'b1;
          occ_nxt    = occ_r - OCC_W'(1);
          cnt_nxt    = cnt_r + 6'd1;
          if (!drain_more) state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_valid_nxt = emit | (out_valid_r & out_stall);

  // Hold state, configuration, the input word and the result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      occ_r          <= '0;
      seq_r          <= '0;
      out_valid_r    <= 1'b0;
      queue_limit_r  <= 5'd16;
      module_count_r <= 3'd1;
      first_ports_r  <= 32'd1;
      last_ports_r   <= 32'd16;
      port_counts_r  <= 20'd16;
      frame_bytes_r  <= 8'd24;
    end else begin
      state_r     <= state_nxt;
      occ_r       <= occ_nxt;
      seq_r       <= seq_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_QUEUE_LIMIT:  queue_limit_r  <= cfg_wdata[4:0];
          REG_MODULE_COUNT: module_count_r <= cfg_wdata[2:0];
          REG_FIRST_PORTS:  first_ports_r  <= cfg_wdata;
          REG_LAST_PORTS:   last_ports_r   <= cfg_wdata;
          REG_PORT_COUNTS:  port_counts_r  <= cfg_wdata[19:0];
          REG_FRAME_BYTES:  frame_bytes_r  <= cfg_wdata[7:0];
          default: ;
        endcase
      end
    end
    mod_r   <= mod_nxt;
    limit_r <= limit_nxt;
    cnt_r   <= cnt_nxt;
    if (in_acc) begin
      act_r <= in_action;
      gp_r  <= in_global_port;
      bc_r  <= in_byte_count;
      b0_r  <= in_byte0;
      b1_r  <= in_byte1;
      b2_r  <= in_byte2;
    end
    if (emit) begin
      out_status_r  <= res_status;
      out_evicted_r <= res_evicted;
      out_entry_r   <= res_entry;
      out_last_r    <= res_last;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_status          = out_status_r;
  assign out_evicted         = out_evicted_r;
  assign out_module_id       = out_entry_r.route[14:13];
  assign out_module_port     = out_entry_r.route[12:8];
  assign out_out_global_port = out_entry_r.route[7:0];
  assign out_out_byte_count  = out_entry_r.msg[25:24];
  assign out_out_byte0       = out_entry_r.msg[23:16];
  assign out_out_byte1       = out_entry_r.msg[15:8];
  assign out_out_byte2       = out_entry_r.msg[7:0];
  assign out_sequence_res    = out_entry_r.stamp;
  assign out_last            = out_last_r;

  `MOQ_ASSERT(a_occ_bound, occ_r <= OCC_W'(SLOT_COUNT), "occupancy above queue depth")
  `MOQ_ASSERT(a_batch_bound, state_r != S_DRAIN || cnt_r < limit_r, "drain batch past its limit")
  `MOQ_ASSERT_NEXT(a_pop_occ, state_r == S_DRAIN && out_free, occ_r == $past(occ_r) - OCC_W'(1), "drain pop did not shrink occupancy")
  `MOQ_ASSERT(a_evict_queued, !out_valid_r || !out_evicted_r || out_status_r == ST_QUEUED, "eviction flagged on a word that was not queued")

endmodule

[sv/moq_cell.sv]
`timescale 1ns / 1ps
module moq_cell (
  input  logic                     clk,
  input  logic [moq_pkg::IDX_W-1:0] cell_idx,
  input  moq_pkg::cell_ctrl_t      ctrl,
  input  logic                     hit_in,
  output logic                     hit_out,
  input  moq_pkg::entry_t          right_data,
  input  moq_pkg::entry_t          new_data,
  output moq_pkg::entry_t          data
);
  import moq_pkg::*;

  entry_t data_r;
  entry_t data_nxt;
  logic   valid;
  logic   keep_off;
  logic   shift;

  // Flag a held entry that is not a Note Off and pass the scan on
  assign valid    = {1'b0, cell_idx} < ctrl.occ;
  assign keep_off = note_off(data_r.msg[25:24], data_r.msg[23:16], data_r.msg[7:0]);
  assign hit_out  = hit_in | (valid & ~keep_off);

  // Shift from the right neighbor at and after the removed entry
  assign shift = ctrl.pop | (ctrl.scan & hit_out);

  always_comb begin
    data_nxt = data_r;
    if (ctrl.load && ctrl.load_idx == cell_idx) data_nxt = new_data;
    else if (shift) data_nxt = right_data;
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data = data_r;

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 1ps
module tb;
  import moq_pkg::*;

  localparam logic        ACT_ENQUEUE     = 1'b0;
  localparam logic        ACT_DRAIN       = 1'b1;
  localparam int unsigned MIN_FRAME       = 24;
  localparam int unsigned FRAME_OVERHEAD  = 17;
  localparam int unsigned BYTES_PER_ENTRY = 5;
  localparam int unsigned SETTLE_CYCLES   = 8;
  localparam int unsigned CYCLE_LIMIT     = 600000;

  typedef struct {
    status_t status;
    logic    evicted;
    entry_t  ent;
    logic    last;
  } result_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic        in_action;
  logic [7:0]  in_global_port;
  logic [2:0]  in_byte_count;
  logic [7:0]  in_byte0;
  logic [7:0]  in_byte1;
  logic [7:0]  in_byte2;
  logic        out_valid;
  logic        out_stall;
  logic [3:0]  out_status;
  logic        out_evicted;
  logic [1:0]  out_module_id;
  logic [4:0]  out_module_port;
  logic [7:0]  out_out_global_port;
  logic [1:0]  out_out_byte_count;
  logic [7:0]  out_out_byte0;
  logic [7:0]  out_out_byte1;
  logic [7:0]  out_out_byte2;
  logic [31:0] out_sequence_res;
  logic        out_last;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_wdata;

  // Shadow of the queue and its registers
  entry_t      queued_entries[$];
  logic [31:0] seq_counter = 32'd0;
  logic [4:0]  qlimit      = 5'd16;
  logic [2:0]  mod_count   = 3'd1;
  logic [31:0] first_ports = 32'd1;
  logic [31:0] last_ports  = 32'd16;
  logic [19:0] port_counts = 20'd16;
  logic [7:0]  frame_len   = 8'd24;

  result_t     expected_results[$];
  int unsigned fail_count     = 0;
  int unsigned cycle_count    = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned recv_hold      = 0;

  midi_output_queue_note_off_keep_core i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_action           (in_action),
    .in_global_port      (in_global_port),
    .in_byte_count       (in_byte_count),
    .in_byte0            (in_byte0),
    .in_byte1            (in_byte1),
    .in_byte2            (in_byte2),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_status          (out_status),
    .out_evicted         (out_evicted),
    .out_module_id       (out_module_id),
    .out_module_port     (out_module_port),
    .out_out_global_port (out_out_global_port),
    .out_out_byte_count  (out_out_byte_count),
    .out_out_byte0       (out_out_byte0),
    .out_out_byte1       (out_out_byte1),
    .out_out_byte2       (out_out_byte2),
    .out_sequence_res    (out_sequence_res),
    .out_last            (out_last),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata)
  );

  always #1 clk = ~clk;

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Drive receiver stall: a long hold-off first, else random stalls
  always @(negedge clk) begin
    if (recv_hold != 0) begin
      out_stall = 1'b1;
      recv_hold = recv_hold - 1;
    end else begin
      out_stall = ($urandom_range(99) < recv_stall_pct);
    end
  end

  function automatic logic is_note_off(logic [1:0] cnt, logic [7:0] stat, logic [7:0] vel);
    if (cnt == 2'd0) return 1'b0;
    if (stat[7:4] == NIB_NOTE_OFF) return 1'b1;
    return stat[7:4] == NIB_NOTE_ON && cnt == 2'd3 && vel == 8'd0;
  endfunction

  function automatic int unsigned active_modules();
    return (mod_count > NUM_MODULES) ? NUM_MODULES : int'(mod_count);
  endfunction

  function automatic void push_result(status_t st, logic ev, entry_t ent, logic last);
    result_t r;
    r.status  = st;
    r.evicted = ev;
    r.ent     = ent;
    r.last    = last;
    expected_results = {expected_results, r};
  endfunction

  function automatic void push_reject(status_t st);
    entry_t blank;
    blank = '0;
    push_result(st, 1'b0, blank, 1'b1);
  endfunction

  // Work out the result words one accepted input word causes
  function automatic void predict_word(logic act, logic [7:0] gp, logic [2:0] cnt,
                                       logic [7:0] b0, logic [7:0] b1, logic [7:0] b2);
    int unsigned nm, m, hit, lim, batch, frame, n, i;
    int          lport;
    logic [7:0]  lo, hi, b1m, b2m;
    logic [4:0]  pc;
    logic [1:0]  head_mod;
    logic        routed, found, ok, ev, more;
    entry_t      ent;
    nm = active_modules();
    if (act == ACT_ENQUEUE) begin
      b1m = (cnt >= 3'd2) ? b1 : 8'd0;
      b2m = (cnt >= 3'd3) ? b2 : 8'd0;
      if (gp == 8'd0) begin
        push_reject(ST_PORT_ZERO);
      end else if (cnt == 3'd0 || cnt > 3'd3) begin
        push_reject(ST_BAD_LENGTH);
      end else if (!b0[7]) begin
        push_reject(ST_NOT_STATUS);
      end else begin
        // First module whose range holds the port wins
        routed = 1'b0;
        hit    = 0;
        for (m = 0; m < nm && !routed; m++) begin
          lo = first_ports[8*m +: 8];
          hi = last_ports[8*m +: 8];
          if (gp >= lo && gp <= hi) begin
            routed = 1'b1;
            hit    = m;
          end
        end
        if (!routed) begin
          push_reject(ST_NO_ROUTE);
        end else begin
          lo    = first_ports[8*hit +: 8];
          pc    = port_counts[5*hit +: 5];
          lport = int'(gp) - int'(lo) + 1;
          if (lport > int'(pc)) begin
            push_reject(ST_LOCAL_OOR);
          end else begin
            lim = (qlimit == 5'd0 || qlimit > SLOT_COUNT) ? SLOT_COUNT : int'(qlimit);
            ok  = 1'b1;
            ev  = 1'b0;
            // At the limit: drop the oldest non Note Off, else fall back
            if (queued_entries.size() >= lim) begin
              found = 1'b0;
              for (i = 0; i < queued_entries.size() && !found; i++) begin
                if (!is_note_off(queued_entries[i].msg[25:24], queued_entries[i].msg[23:16],
                                 queued_entries[i].msg[7:0])) begin
                  queued_entries.delete(i);
                  found = 1'b1;
                end
              end
              if (!found) begin
                if (is_note_off(cnt[1:0], b0, b2m) && queued_entries.size() > 0) begin
                  queued_entries.delete(0);
                end else begin
                  push_reject(ST_OVERFLOW);
                  ok = 1'b0;
                end
              end
              ev = 1'b1;
            end
            if (ok) begin
              seq_counter = seq_counter + 32'd1;
              ent.route   = {hit[1:0], lport[4:0], gp};
              ent.msg     = {cnt[1:0], b0, b1m, b2m};
              ent.stamp   = seq_counter;
              if (queued_entries.size() < SLOT_COUNT) begin
                queued_entries = {queued_entries, ent};
              end
              push_result(ST_QUEUED, ev, ent, 1'b1);
            end
          end
        end
      end
    end else begin
      if (queued_entries.size() == 0) begin
        push_reject(ST_EMPTY);
      end else begin
        // Pop a batch for the head's module
        head_mod = queued_entries[0].route[14:13];
        batch    = 1;
        if (32'(head_mod) < nm) begin
          frame = (frame_len < MIN_FRAME) ? MIN_FRAME : int'(frame_len);
          batch = (frame - FRAME_OVERHEAD) / BYTES_PER_ENTRY;
          if (batch < 1) batch = 1;
        end
        n = 0;
        do begin
          ent = queued_entries[0];
          queued_entries.delete(0);
          n++;
          more = queued_entries.size() > 0 && n < batch &&
                 queued_entries[0].route[14:13] == head_mod;
          push_result(ST_ITEM, 1'b0, ent, !more);
        end while (more);
      end
    end
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      fail_count++;
    end
  endfunction

  // Compare each accepted result word with the oldest expected one
  always @(posedge clk) begin : check_results
    result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result word with status %0d", out_status);
        fail_count++;
      end else begin
        want = expected_results[0];
        expected_results.delete(0);
        check_field("status", 32'(want.status), 32'(out_status));
        check_field("evicted", 32'(want.evicted), 32'(out_evicted));
        check_field("module_id", 32'(want.ent.route[14:13]), 32'(out_module_id));
        check_field("module_port", 32'(want.ent.route[12:8]), 32'(out_module_port));
        check_field("out_global_port", 32'(want.ent.route[7:0]), 32'(out_out_global_port));
        check_field("out_byte_count", 32'(want.ent.msg[25:24]), 32'(out_out_byte_count));
        check_field("out_byte0", 32'(want.ent.msg[23:16]), 32'(out_out_byte0));
        check_field("out_byte1", 32'(want.ent.msg[15:8]), 32'(out_out_byte1));
        check_field("out_byte2", 32'(want.ent.msg[7:0]), 32'(out_out_byte2));
        check_field("sequence_res", want.ent.stamp, out_sequence_res);
        check_field("last", 32'(want.last), 32'(out_last));
      end
    end
  end

  // Offer one input word after random idle cycles, predict on acceptance
  task automatic send_word(input logic act, input logic [7:0] gp, input logic [2:0] cnt,
                           input logic [7:0] b0, input logic [7:0] b1, input logic [7:0] b2);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid       = 1'b1;
    in_action      = act;
    in_global_port = gp;
    in_byte_count  = cnt;
    in_byte0       = b0;
    in_byte1       = b1;
    in_byte2       = b2;
    do @(posedge clk); while (in_stall);
    predict_word(act, gp, cnt, b0, b1, b2);
  endtask

  task automatic enqueue(input logic [7:0] gp, input logic [2:0] cnt, input logic [7:0] b0,
                         input logic [7:0] b1, input logic [7:0] b2);
    send_word(ACT_ENQUEUE, gp, cnt, b0, b1, b2);
  endtask

  // Drain with random don't-care fields
  task automatic drain_word();
    send_word(ACT_DRAIN, 8'($urandom), 3'($urandom), 8'($urandom), 8'($urandom),
              8'($urandom));
  endtask

  // Mostly well-formed enqueues to configured ports, some drains and noise
  task automatic random_word(input int unsigned drain_pct);
    int unsigned pick, nm, m;
    logic [7:0]  lo, hi, gp, b0, b1, b2;
    logic [2:0]  cnt;
    pick = $urandom_range(99);
    if (pick < drain_pct) begin
      drain_word();
    end else if (pick >= 90) begin
      send_word(1'($urandom), 8'($urandom), 3'($urandom), 8'($urandom), 8'($urandom),
                8'($urandom));
    end else begin
      nm = active_modules();
      gp = 8'($urandom);
      if (nm > 0) begin
        m  = $urandom_range(nm - 1);
        lo = first_ports[8*m +: 8];
        hi = last_ports[8*m +: 8];
        if (hi >= lo) gp = lo + 8'($urandom_range(int'(hi - lo)));
      end
      cnt = 3'($urandom_range(3, 1));
      b1  = 8'($urandom);
      b2  = 8'($urandom);
      case ($urandom_range(3))
        0: b0 = {NIB_NOTE_OFF, 4'($urandom)};
        1: begin
          b0  = {NIB_NOTE_ON, 4'($urandom)};
          cnt = 3'd3;
          b2  = 8'd0;
        end
        2: b0 = {NIB_NOTE_ON, 4'($urandom)};
        default: b0 = {1'b1, 7'($urandom)};
      endcase
      enqueue(gp, cnt, b0, b1, b2);
    end
  endtask

  task automatic run_random(input int unsigned count, input int unsigned drain_pct);
    repeat (count) random_word(drain_pct);
  endtask

  // Drop valid and wait for every expected word
  task automatic hold_until_drained();
    @(negedge clk);
    in_valid = 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic wait_quiet();
    hold_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_wdata = data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_QUEUE_LIMIT:  qlimit      = data[4:0];
      REG_MODULE_COUNT: mod_count   = data[2:0];
      REG_FIRST_PORTS:  first_ports = data;
      REG_LAST_PORTS:   last_ports  = data;
      REG_PORT_COUNTS:  port_counts = data[19:0];
      REG_FRAME_BYTES:  frame_len   = data[7:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic set_idle(input int unsigned send_pct, input int unsigned recv_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  // Four modules, module 1 overlapping module 0, module 2 short of ports
  task automatic set_four_modules(input logic [4:0] lim, input logic [2:0] cnt,
                                  input logic [7:0] frame);
    wait_quiet();
    write_reg(REG_QUEUE_LIMIT, {27'd0, lim});
    write_reg(REG_MODULE_COUNT, {29'd0, cnt});
    write_reg(REG_FIRST_PORTS, 32'hF0_21_0C_01);
    write_reg(REG_LAST_PORTS, 32'hFF_30_20_10);
    write_reg(REG_PORT_COUNTS, {12'd0, 5'd16, 5'd8, 5'd21, 5'd16});
    write_reg(REG_FRAME_BYTES, {24'd0, frame});
  endtask

  task automatic test_directed();
    set_idle(0, 0);
    drain_word();
    enqueue(8'd0, 3'd1, 8'h90, 8'h3C, 8'h40);
    enqueue(8'd1, 3'd0, 8'h90, 8'h3C, 8'h40);
    enqueue(8'd1, 3'd4, 8'h90, 8'h3C, 8'h40);
    enqueue(8'd1, 3'd7, 8'h90, 8'h3C, 8'h40);
    enqueue(8'd1, 3'd2, 8'h7F, 8'h3C, 8'h40);
    enqueue(8'd17, 3'd1, 8'hF8, 8'h00, 8'h00);
    enqueue(8'hFF, 3'd3, 8'hFF, 8'hFF, 8'hFF);
    // Bytes past the count read as zero
    enqueue(8'd1, 3'd1, 8'h80, 8'hFF, 8'hFF);
    enqueue(8'd16, 3'd3, 8'hFF, 8'h00, 8'hFF);
    enqueue(8'd5, 3'd3, 8'h9F, 8'h7F, 8'h00);
    enqueue(8'd5, 3'd2, 8'h90, 8'h40, 8'h00);
    repeat (4) drain_word();
    // Tight limit, fewer local ports, widest frame
    wait_quiet();
    write_reg(REG_PORT_COUNTS, 32'd8);
    write_reg(REG_QUEUE_LIMIT, 32'd2);
    write_reg(REG_FRAME_BYTES, 32'd255);
    enqueue(8'd9, 3'd1, 8'h80, 8'h00, 8'h00);
    enqueue(8'd8, 3'd3, 8'h85, 8'h3C, 8'h00);
    enqueue(8'd2, 3'd1, 8'h8A, 8'h00, 8'h00);
    // All entries Note Off: a Note Off takes the head, anything else overflows
    enqueue(8'd3, 3'd3, 8'h90, 8'h40, 8'h00);
    enqueue(8'd4, 3'd3, 8'h90, 8'h40, 8'h7F);
    drain_word();
    enqueue(8'd4, 3'd2, 8'hC0, 8'h05, 8'h00);
    enqueue(8'd6, 3'd1, 8'h80, 8'h00, 8'h00);
    enqueue(8'd7, 3'd3, 8'hB0, 8'h07, 8'h64);
    drain_word();
  endtask

  task automatic test_multi_module();
    set_four_modules(5'd4, 3'd4, 8'd255);
    set_idle(0, 0);
    run_random(40, 30);
  endtask

  task automatic test_tiny_frame();
    set_four_modules(5'd0, 3'd7, 8'd0);
    set_idle(70, 0);
    run_random(60, 25);
  endtask

  task automatic test_limit_above_depth();
    set_four_modules(5'd31, 3'd4, 8'd40);
    set_idle(0, 70);
    run_random(60, 15);
  endtask

  task automatic test_lowered_limit();
    set_four_modules(5'd16, 3'd4, 8'd60);
    set_idle(0, 0);
    run_random(12, 0);
    wait_quiet();
    write_reg(REG_QUEUE_LIMIT, 32'd3);
    set_idle(38, 38);
    run_random(50, 10);
  endtask

  task automatic test_module_gone();
    set_four_modules(5'd16, 3'd4, 8'd255);
    set_idle(38, 38);
    run_random(10, 0);
    // Heads past the module count drain one at a time
    wait_quiet();
    write_reg(REG_MODULE_COUNT, 32'd1);
    run_random(12, 50);
    wait_quiet();
    write_reg(REG_MODULE_COUNT, 32'd0);
    run_random(10, 50);
  endtask

  task automatic test_backpressure();
    set_four_modules(5'd0, 3'd4, 8'd255);
    set_idle(0, 0);
    recv_hold = 400;
    run_random(30, 20);
    hold_until_drained();
    set_idle(38, 38);
    run_random(30, 25);
  endtask

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_action      = ACT_ENQUEUE;
    in_global_port = 8'd0;
    in_byte_count  = 3'd0;
    in_byte0       = 8'd0;
    in_byte1       = 8'd0;
    in_byte2       = 8'd0;
    out_stall      = 1'b0;
    cfg_valid      = 1'b0;
    cfg_index      = REG_QUEUE_LIMIT;
    cfg_wdata      = 32'd0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_multi_module();
    test_tiny_frame();
    test_limit_above_depth();
    test_lowered_limit();
    test_module_gone();
    test_backpressure();

    wait_quiet();
    repeat (60) @(posedge clk);
    if (fail_count == 0 && expected_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+sv
sv/moq_pkg.sv
sv/moq_cell.sv
sv/midi_output_queue_note_off_keep_core.sv
tb/sv/tb.sv
